// ===== hw/rtl/mer_pkg.sv =====
// Package for the midpoint ellipse rasterizer: widths, state and datapath
// operation codes, and the command/status structs between controller and datapath.
// No dependencies.
package mer_pkg;

  // Semi-axes are taken to AXIS_BITS bits (never wider than the input field)
  localparam int AXIS_BITS = 9;
  localparam int SEMI_W    = 9;
  localparam int COORD_W   = 10;
  localparam int PIX_W     = 12;
  localparam int AXIS_W    = (AXIS_BITS < SEMI_W) ? AXIS_BITS : SEMI_W;

  // Datapath widths, all derived from the semi-axis width
  localparam int WX_W    = AXIS_W + 1;         // walk column
  localparam int TX_W    = AXIS_W + 2;         // 2x+1
  localparam int SQ_W    = 2 * AXIS_W;         // a^2, b^2
  localparam int SLOPE_W = 3 * AXIS_W + 3;     // 2*b^2*x, 2*a^2*y
  localparam int DEC_W   = 4 * AXIS_W + 8;     // decision, scaled by 4
  localparam int MUL_A_W = SQ_W;
  localparam int MUL_B_W = 2 * TX_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Stream payload widths
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 24;

  // Input command kinds
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_AB,
    ST_INIT,
    ST_CHK,
    ST_R1_MOVE,
    ST_R1_DEC,
    ST_R2_MOVE,
    ST_R2_DEC,
    ST_SU_TX,
    ST_SU_BTX,
    ST_SU_TY,
    ST_SU_ATY,
    ST_SU_AB,
    ST_SU_DEC,
    ST_EMIT,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,      // take center and semi-axes, reset the walk
    DP_SQ_A,       // prod = a*a
    DP_SQ_B,       // a2 = prod, prod = b*b
    DP_AB,         // b2 = prod, prod = a2*b
    DP_INIT,       // slope_y and region 1 decision from prod
    DP_R1_MOVE,
    DP_R1_DEC,
    DP_R2_MOVE,
    DP_R2_DEC,
    DP_SU_TX,      // prod = (2x+1)^2
    DP_SU_BTX,     // prod = b2 * prod
    DP_SU_TY,      // acc = prod, prod = (y-1)^2
    DP_SU_ATY,     // prod = a2 * prod
    DP_SU_AB,      // acc += 4*prod, prod = a2*b2
    DP_SU_DEC,     // decision = acc - 4*prod, enter region 2
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       out_load;
    logic       out_done;
    logic [1:0] pix_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic region_two;
    logic y_zero;
    logic slope_ge;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/mer_ctrl.sv =====
// Controller of the midpoint ellipse rasterizer: sequences set-up, walk steps,
// region switch and pixel output. Depends on mer_pkg.
module mer_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_ready,
  input  mer_pkg::dp_stat_t stat,
  output mer_pkg::dp_cmd_t  cmd
);

  mer_pkg::state_t state, state_next;
  logic [1:0]      pix_idx, pix_idx_next;

  // State and pixel counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mer_pkg::ST_IDLE;
      pix_idx <= '0;
    end else begin
      state   <= state_next;
      pix_idx <= pix_idx_next;
    end
  end

  // Next state
  always_comb begin
    state_next   = state;
    pix_idx_next = pix_idx;
    case (state)
      mer_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_command == mer_pkg::CMD_START) begin
            state_next = mer_pkg::ST_SQ_A;
          end else if (stat.finished) begin
            state_next = mer_pkg::ST_DONE;
          end else if (stat.region_two && stat.y_zero) begin
            state_next = mer_pkg::ST_DONE;
          end else if (stat.region_two) begin
            state_next = mer_pkg::ST_R2_MOVE;
          end else begin
            state_next = mer_pkg::ST_R1_MOVE;
          end
        end
      end
      mer_pkg::ST_SQ_A:    state_next = mer_pkg::ST_SQ_B;
      mer_pkg::ST_SQ_B:    state_next = mer_pkg::ST_AB;
      mer_pkg::ST_AB:      state_next = mer_pkg::ST_INIT;
      mer_pkg::ST_INIT:    state_next = mer_pkg::ST_CHK;
      mer_pkg::ST_CHK:     state_next = stat.slope_ge ? mer_pkg::ST_SU_TX : mer_pkg::ST_EMIT;
      mer_pkg::ST_R1_MOVE: state_next = mer_pkg::ST_R1_DEC;
      mer_pkg::ST_R1_DEC:  state_next = mer_pkg::ST_CHK;
      mer_pkg::ST_R2_MOVE: state_next = mer_pkg::ST_R2_DEC;
      mer_pkg::ST_R2_DEC:  state_next = mer_pkg::ST_EMIT;
      mer_pkg::ST_SU_TX:   state_next = mer_pkg::ST_SU_BTX;
      mer_pkg::ST_SU_BTX:  state_next = mer_pkg::ST_SU_TY;
      mer_pkg::ST_SU_TY:   state_next = mer_pkg::ST_SU_ATY;
      mer_pkg::ST_SU_ATY:  state_next = mer_pkg::ST_SU_AB;
      mer_pkg::ST_SU_AB:   state_next = mer_pkg::ST_SU_DEC;
      mer_pkg::ST_SU_DEC:  state_next = mer_pkg::ST_EMIT;
      mer_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          pix_idx_next = pix_idx + 2'd1;
          if (&pix_idx) begin
            state_next = mer_pkg::ST_IDLE;
          end
        end
      end
      mer_pkg::ST_DONE: begin
        if (stat.out_free) begin
          state_next = mer_pkg::ST_IDLE;
        end
      end
      default: state_next = mer_pkg::ST_IDLE;
    endcase
  end

  // Outputs: datapath command and input ready
  always_comb begin
    in_ready     = 1'b0;
    cmd.op       = mer_pkg::DP_NOP;
    cmd.out_load = 1'b0;
    cmd.out_done = 1'b0;
    cmd.pix_sel  = pix_idx;
    case (state)
      mer_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == mer_pkg::CMD_START) begin
            cmd.op = mer_pkg::DP_LATCH;
          end else if (!stat.finished && stat.region_two && stat.y_zero) begin
            cmd.op = mer_pkg::DP_FINISH;
          end
        end
      end
      mer_pkg::ST_SQ_A:    cmd.op = mer_pkg::DP_SQ_A;
      mer_pkg::ST_SQ_B:    cmd.op = mer_pkg::DP_SQ_B;
      mer_pkg::ST_AB:      cmd.op = mer_pkg::DP_AB;
      mer_pkg::ST_INIT:    cmd.op = mer_pkg::DP_INIT;
      mer_pkg::ST_CHK:     cmd.op = mer_pkg::DP_NOP;
      mer_pkg::ST_R1_MOVE: cmd.op = mer_pkg::DP_R1_MOVE;
      mer_pkg::ST_R1_DEC:  cmd.op = mer_pkg::DP_R1_DEC;
      mer_pkg::ST_R2_MOVE: cmd.op = mer_pkg::DP_R2_MOVE;
      mer_pkg::ST_R2_DEC:  cmd.op = mer_pkg::DP_R2_DEC;
      mer_pkg::ST_SU_TX:   cmd.op = mer_pkg::DP_SU_TX;
      mer_pkg::ST_SU_BTX:  cmd.op = mer_pkg::DP_SU_BTX;
      mer_pkg::ST_SU_TY:   cmd.op = mer_pkg::DP_SU_TY;
      mer_pkg::ST_SU_ATY:  cmd.op = mer_pkg::DP_SU_ATY;
      mer_pkg::ST_SU_AB:   cmd.op = mer_pkg::DP_SU_AB;
      mer_pkg::ST_SU_DEC:  cmd.op = mer_pkg::DP_SU_DEC;
      mer_pkg::ST_EMIT:    cmd.out_load = stat.out_free;
      mer_pkg::ST_DONE: begin
        cmd.out_load = stat.out_free;
        cmd.out_done = 1'b1;
      end
      default: cmd.op = mer_pkg::DP_NOP;
    endcase
  end

endmodule

// ===== hw/rtl/mer_datapath.sv =====
// Datapath of the midpoint ellipse rasterizer: walk registers, shared
// multiplier, decision update and the output register. Depends on mer_pkg.
module mer_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mer_pkg::dp_cmd_t                     cmd,
  output mer_pkg::dp_stat_t                    stat,
  input  logic [mer_pkg::COORD_W-1:0]          center_x,
  input  logic [mer_pkg::COORD_W-1:0]          center_y,
  input  logic [mer_pkg::SEMI_W-1:0]           semi_a,
  input  logic [mer_pkg::SEMI_W-1:0]           semi_b,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mer_pkg::PIX_W-1:0]     pixel_x,
  output logic signed [mer_pkg::PIX_W-1:0]     pixel_y,
  output logic                                 pixel_valid,
  output logic                                 last,
  output logic                                 done_res
);

  localparam int A = mer_pkg::AXIS_W;

  // Walk and set-up state
  logic [mer_pkg::COORD_W-1:0]       held_cx, held_cy;
  logic [A-1:0]                      hold_a, hold_b;
  logic [mer_pkg::SQ_W-1:0]          a2, b2;
  logic [mer_pkg::WX_W-1:0]          walk_x;
  logic [A-1:0]                      walk_y;
  logic signed [mer_pkg::SLOPE_W-1:0] slope_x, slope_y;
  logic signed [mer_pkg::DEC_W-1:0]  decision, acc;
  logic [mer_pkg::PROD_W-1:0]        prod;
  logic                              diag;
  logic                              finished, in_region_two;

  // Shared multiplier operands
  logic [mer_pkg::MUL_A_W-1:0]       mul_a;
  logic [mer_pkg::MUL_B_W-1:0]       mul_b;
  logic [mer_pkg::TX_W-1:0]          tx;
  logic [A-1:0]                      ty_abs;

  // Sign-extended terms for the decision update
  logic signed [mer_pkg::DEC_W-1:0]  sx_e, sy_e, a2_e, b2_e, prod4_e;
  logic signed [mer_pkg::SLOPE_W-1:0] two_a2, two_b2;

  assign tx     = {walk_x, 1'b1};
  assign ty_abs = (walk_y == '0) ? A'(1) : walk_y - A'(1);
  assign sx_e   = mer_pkg::DEC_W'(slope_x);
  assign sy_e   = mer_pkg::DEC_W'(slope_y);
  assign a2_e   = $signed(mer_pkg::DEC_W'(a2));
  assign b2_e   = $signed(mer_pkg::DEC_W'(b2));
  assign prod4_e = $signed(mer_pkg::DEC_W'({prod, 2'b00}));
  assign two_a2 = $signed(mer_pkg::SLOPE_W'({a2, 1'b0}));
  assign two_b2 = $signed(mer_pkg::SLOPE_W'({b2, 1'b0}));

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      mer_pkg::DP_SQ_A: begin
        mul_a = mer_pkg::MUL_A_W'(hold_a);
        mul_b = mer_pkg::MUL_B_W'(hold_a);
      end
      mer_pkg::DP_SQ_B: begin
        mul_a = mer_pkg::MUL_A_W'(hold_b);
        mul_b = mer_pkg::MUL_B_W'(hold_b);
      end
      mer_pkg::DP_AB: begin
        mul_a = a2;
        mul_b = mer_pkg::MUL_B_W'(hold_b);
      end
      mer_pkg::DP_SU_TX: begin
        mul_a = mer_pkg::MUL_A_W'(tx);
        mul_b = mer_pkg::MUL_B_W'(tx);
      end
      mer_pkg::DP_SU_BTX: begin
        mul_a = b2;
        mul_b = prod[mer_pkg::MUL_B_W-1:0];
      end
      mer_pkg::DP_SU_TY: begin
        mul_a = mer_pkg::MUL_A_W'(ty_abs);
        mul_b = mer_pkg::MUL_B_W'(ty_abs);
      end
      mer_pkg::DP_SU_ATY: begin
        mul_a = a2;
        mul_b = prod[mer_pkg::MUL_B_W-1:0];
      end
      mer_pkg::DP_SU_AB: begin
        mul_a = a2;
        mul_b = mer_pkg::MUL_B_W'(b2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Control state: walk flags
  always_ff @(posedge clk) begin
    if (rst) begin
      finished      <= 1'b1;
      in_region_two <= 1'b0;
    end else begin
      case (cmd.op)
        mer_pkg::DP_LATCH: begin
          finished      <= 1'b0;
          in_region_two <= 1'b0;
        end
        mer_pkg::DP_SU_DEC: in_region_two <= 1'b1;
        mer_pkg::DP_FINISH: finished      <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload state: walk point, slope terms, decision, multiplier
  always_ff @(posedge clk) begin
    case (cmd.op)
      mer_pkg::DP_LATCH: begin
        held_cx <= center_x;
        held_cy <= center_y;
        hold_a  <= semi_a[A-1:0];
        hold_b  <= semi_b[A-1:0];
        walk_x  <= '0;
        walk_y  <= semi_b[A-1:0];
        slope_x <= '0;
      end
      mer_pkg::DP_SQ_A: prod <= mul_a * mul_b;
      mer_pkg::DP_SQ_B: begin
        a2   <= prod[mer_pkg::SQ_W-1:0];
        prod <= mul_a * mul_b;
      end
      mer_pkg::DP_AB: begin
        b2   <= prod[mer_pkg::SQ_W-1:0];
        prod <= mul_a * mul_b;
      end
      mer_pkg::DP_INIT: begin
        // prod holds a^2*b here
        slope_y  <= $signed(mer_pkg::SLOPE_W'({prod, 1'b0}));
        decision <= (b2_e <<< 2) - prod4_e + a2_e;
      end
      mer_pkg::DP_R1_MOVE: begin
        walk_x  <= walk_x + mer_pkg::WX_W'(1);
        slope_x <= slope_x + two_b2;
        diag    <= !decision[mer_pkg::DEC_W-1];
        if (!decision[mer_pkg::DEC_W-1]) begin
          walk_y  <= walk_y - A'(1);
          slope_y <= slope_y - two_a2;
        end
      end
      mer_pkg::DP_R1_DEC: begin
        if (diag) begin
          decision <= decision + ((sx_e - sy_e + b2_e) <<< 2);
        end else begin
          decision <= decision + ((sx_e + b2_e) <<< 2);
        end
      end
      mer_pkg::DP_R2_MOVE: begin
        walk_y  <= walk_y - A'(1);
        slope_y <= slope_y - two_a2;
        // x moves when the decision is not above zero
        diag    <= decision[mer_pkg::DEC_W-1] || (decision == '0);
        if (decision[mer_pkg::DEC_W-1] || (decision == '0)) begin
          walk_x  <= walk_x + mer_pkg::WX_W'(1);
          slope_x <= slope_x + two_b2;
        end
      end
      mer_pkg::DP_R2_DEC: begin
        if (diag) begin
          decision <= decision + ((sx_e - sy_e + a2_e) <<< 2);
        end else begin
          decision <= decision + ((a2_e - sy_e) <<< 2);
        end
      end
      mer_pkg::DP_SU_TX:  prod <= mul_a * mul_b;
      mer_pkg::DP_SU_BTX: prod <= mul_a * mul_b;
      mer_pkg::DP_SU_TY: begin
        acc  <= $signed(mer_pkg::DEC_W'(prod));
        prod <= mul_a * mul_b;
      end
      mer_pkg::DP_SU_ATY: prod <= mul_a * mul_b;
      mer_pkg::DP_SU_AB: begin
        acc  <= acc + prod4_e;
        prod <= mul_a * mul_b;
      end
      mer_pkg::DP_SU_DEC: decision <= acc - prod4_e;
      default: ;
    endcase
  end

  // Status toward the controller
  assign stat.finished   = finished;
  assign stat.region_two = in_region_two;
  assign stat.y_zero     = (walk_y == '0);
  assign stat.slope_ge   = (slope_x >= slope_y);
  assign stat.out_free   = !out_valid || out_ready;

  // Mirror the walk point into the selected pixel
  logic [mer_pkg::PIX_W-1:0] cx_e, cy_e, x_e, y_e;
  assign cx_e = mer_pkg::PIX_W'(held_cx);
  assign cy_e = mer_pkg::PIX_W'(held_cy);
  assign x_e  = mer_pkg::PIX_W'(walk_x);
  assign y_e  = mer_pkg::PIX_W'(walk_y);

  // Output register: load a result or drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_done) begin
        pixel_x     <= '0;
        pixel_y     <= '0;
        pixel_valid <= 1'b0;
        last        <= 1'b1;
        done_res    <= 1'b1;
      end else begin
        pixel_x     <= cmd.pix_sel[0] ? (cx_e - x_e) : (cx_e + x_e);
        pixel_y     <= (cmd.pix_sel[0] ^ cmd.pix_sel[1]) ? (cy_e - y_e) : (cy_e + y_e);
        pixel_valid <= 1'b1;
        last        <= &cmd.pix_sel;
        done_res    <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/midpoint_ellipse_rasterizer.sv =====
// Top level of the midpoint ellipse rasterizer: stream ports, controller and
// datapath. Depends on mer_pkg, mer_ctrl and mer_datapath.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata: center/semi-axes, tuser: command
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata: pixel, tuser: flags, tlast
//
// Start: accept, 3 multiplies on the shared multiplier, init, check, four pixel
// outputs; a zero slope term sends it to the region 2 set-up multiplies and adds first.
// Step: accept, move, decision update, a check in region 1 (with the set-up on
// the region switch), then the pixel outputs; a done result is one output.
// One item at a time; output back-pressure stretches the output cycles.
// Reset (rst, synchronous) leaves the walk finished and the output empty.
module midpoint_ellipse_rasterizer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [9:0] center_x, [19:10] center_y, [28:20] semi_a, [37:29] semi_b, [39:38] zero
  input  logic [mer_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // [0] command
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [11:0] pixel_x, [23:12] pixel_y
  output logic [mer_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // [0] pixel_valid, [1] done_res
  output logic [1:0]                     m_axis_tuser,
  output logic                           m_axis_tlast
);

  mer_pkg::dp_cmd_t  cmd;
  mer_pkg::dp_stat_t stat;

  logic signed [mer_pkg::PIX_W-1:0] pixel_x, pixel_y;
  logic                             pixel_valid, done_res;

  // Sequence each transaction
  mer_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_command (s_axis_tuser[0]),
    .in_ready   (s_axis_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Walk arithmetic and result register
  mer_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .center_x    (s_axis_tdata[9:0]),
    .center_y    (s_axis_tdata[19:10]),
    .semi_a      (s_axis_tdata[28:20]),
    .semi_b      (s_axis_tdata[37:29]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_valid (pixel_valid),
    .last        (m_axis_tlast),
    .done_res    (done_res)
  );

  // Pack the result transaction
  assign m_axis_tdata = {pixel_y, pixel_x};
  assign m_axis_tuser = {done_res, pixel_valid};

endmodule
